[src/qltu_pkg.sv]
package qltu_pkg;

	localparam int NUM_STATES  = 4;
	localparam int NUM_ACTIONS = 3;
	localparam int TBL_DEPTH   = NUM_STATES * NUM_ACTIONS;
	localparam int ADDR_W      = $clog2(TBL_DEPTH);
	localparam int ACT_W       = $clog2(NUM_ACTIONS);
	localparam int CNT_W       = $clog2(NUM_ACTIONS + 1);
	localparam int STATE_W     = 2;

	localparam int DIV_STEPS = 7;
	localparam int DCNT_W    = 3;

	// x / 100 == (x * RECIP_100) >> RECIP_SHIFT for every x below 91180.
	localparam logic [16:0] RECIP_100   = 17'd83887;
	localparam int          RECIP_SHIFT = 23;
	localparam logic [16:0] PCT         = 17'd100;

	localparam logic [6:0] BIN_EDGE_1 = 7'd25;
	localparam logic [6:0] BIN_EDGE_2 = 7'd50;
	localparam logic [6:0] BIN_EDGE_3 = 7'd75;

	localparam logic [6:0] ALPHA_RST   = 7'd30;
	localparam logic [6:0] GAMMA_RST   = 7'd90;
	localparam logic [6:0] LOW_BAT_RST = 7'd20;
	localparam logic [6:0] PENALTY_RST = 7'd15;

	localparam logic [7:0] REG_ALPHA   = 8'd0;
	localparam logic [7:0] REG_GAMMA   = 8'd1;
	localparam logic [7:0] REG_LOW_BAT = 8'd2;
	localparam logic [7:0] REG_PENALTY = 8'd3;

	localparam logic signed [3:0] NUDGE_DOWN = -4'sd5;
	localparam logic signed [3:0] NUDGE_UP   = 4'sd5;
	localparam logic signed [3:0] NUDGE_NONE = 4'sd0;

	localparam logic signed [11:0] VAL_MAX = 12'sd127;
	localparam logic signed [11:0] VAL_MIN = -12'sd128;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} tbl_wr_t;

endpackage

[src/qltu_value_mem.sv]
module qltu_value_mem (
	input  logic                        clk,
	input  logic                        arst_n,
	input  qltu_pkg::tbl_wr_t           wr,
	input  logic [qltu_pkg::ADDR_W-1:0] rd_addr,
	output logic signed [7:0]           rd_data
);
	import qltu_pkg::*;

	logic [7:0]           mem [TBL_DEPTH];
	logic [TBL_DEPTH-1:0] vld_q;
	logic [7:0]           rd_q;
	logic                 rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_q <= mem[rd_addr];
	end

	// Entries never written read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? $signed(rd_q) : 8'sd0;

endmodule

[src/qlearning_table_update_top.sv]
// Q-learning table update for a battery-binned routing state.
// The input stream carries one word per routing period: delivered count,
// attempted count and battery percent. Each word with a nonzero attempted
// count updates one entry of a 4 x 3 table of signed 8-bit action values
// and produces one output word: the greedy action, its gamma nudge, the
// battery bin and the saturated value just written. A word with a zero
// attempted count is taken and changes nothing.
// The block works on one word at a time and takes the next word only after
// the output register has been loaded. An update runs through the
// seven-step restoring divider for the reward ratio, the scans of the next
// state's row through the table's single read port before and after the
// write, and the shared multiplier used for the scaling steps.
// A finished output word waits in its own register; the block takes the
// next input word while it waits, and stalls before its own result only if
// the previous one has still not been taken.
// The configuration channel is always ready. Reset makes every table entry
// read as zero, sets the previous state to 0 and the previous action to 1, and
// loads the register defaults 30, 90, 20 and 15.
module qlearning_table_update_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [15:0] delivered_count, [31:16] attempted_count, [38:32] battery_pct, [39] zero
	input  logic [39:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [1:0] chosen_action, [5:2] gamma_nudge, [7:6] battery_bin, [15:8] updated_value
	output logic [15:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [6:0]  cfg_data
);
	import qltu_pkg::*;

	typedef enum logic [12:0] {
		ST_IDLE  = 13'b0000000000001,
		ST_LOAD  = 13'b0000000000010,
		ST_DIV   = 13'b0000000000100,
		ST_SCAN1 = 13'b0000000001000,
		ST_RDQ   = 13'b0000000010000,
		ST_M1    = 13'b0000000100000,
		ST_M2    = 13'b0000001000000,
		ST_TD    = 13'b0000010000000,
		ST_M3    = 13'b0000100000000,
		ST_M4    = 13'b0001000000000,
		ST_WR    = 13'b0010000000000,
		ST_SCAN2 = 13'b0100000000000,
		ST_FIN   = 13'b1000000000000
	} state_t;

	state_t state_q;

	logic [6:0] alpha_q, gamma_q, low_bat_q, penalty_q;

	logic [STATE_W-1:0] prev_state_q;
	logic [ACT_W-1:0]   prev_action_q;

	logic [15:0]        ok_q, tot_q;
	logic               low_q;
	logic [STATE_W-1:0] s2_q;
	logic [22:0]        rem_q, dsr_q;
	logic [6:0]         quot_q;
	logic [DCNT_W-1:0]  div_cnt_q;
	logic [CNT_W-1:0]   cnt_q;
	logic signed [7:0]  best_q;
	logic [ACT_W-1:0]   pick_q;
	logic signed [7:0]  q_q;
	logic [33:0]        prod_q;
	logic               neg_q;
	logic [9:0]         tdabs_q;
	logic [7:0]         upd_q;

	logic        m_tvalid_q;
	logic [15:0] m_data_q;

	logic [15:0] in_ok, in_tot;
	logic [6:0]  in_batt;
	logic        in_acc;
	logic [STATE_W-1:0] in_bin;

	logic [16:0] mul_a, mul_b;
	logic [33:0] mul_p;

	logic [ADDR_W-1:0]  scan_addr, qa_addr, rd_addr;
	logic signed [7:0]  rd_data;
	tbl_wr_t            tbl_wr;

	logic [CNT_W-1:0]   scan_prev;
	logic               scan_done;
	logic [7:0]         best_abs;
	logic signed [8:0]  reward;
	logic signed [9:0]  gval;
	logic signed [10:0] td;
	logic [10:0]        td_abs;
	logic signed [11:0] delta, q_new;
	logic [7:0]         q_sat;
	logic               fin_load;
	logic signed [3:0]  nudge;

	assign in_ok   = s_axis_tdata[15:0];
	assign in_tot  = s_axis_tdata[31:16];
	assign in_batt = s_axis_tdata[38:32];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	always_comb begin
		priority if (in_batt < BIN_EDGE_1) begin
			in_bin = STATE_W'(0);
		end else if (in_batt < BIN_EDGE_2) begin
			in_bin = STATE_W'(1);
		end else if (in_batt < BIN_EDGE_3) begin
			in_bin = STATE_W'(2);
		end else begin
			in_bin = STATE_W'(3);
		end
	end

	// Shared multiplier for the count scaling, the gamma and alpha products and both divisions by 100.
	assign best_abs = best_q[7] ? 8'(-best_q) : 8'(best_q);

	always_comb begin
		unique case (state_q)
			ST_LOAD: begin
				mul_a = 17'(ok_q);
				mul_b = PCT;
			end
			ST_M1: begin
				mul_a = 17'(best_abs);
				mul_b = 17'(gamma_q);
			end
			ST_M3: begin
				mul_a = 17'(tdabs_q);
				mul_b = 17'(alpha_q);
			end
			ST_M2, ST_M4: begin
				mul_a = prod_q[16:0];
				mul_b = RECIP_100;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = 34'(mul_a) * 34'(mul_b);

	assign scan_addr = ADDR_W'(ADDR_W'(s2_q) * ADDR_W'(NUM_ACTIONS) + ADDR_W'(cnt_q[ACT_W-1:0]));
	assign qa_addr   = ADDR_W'(ADDR_W'(prev_state_q) * ADDR_W'(NUM_ACTIONS)
		+ ADDR_W'(prev_action_q));
	assign rd_addr   = (state_q == ST_SCAN1 || state_q == ST_SCAN2) ? scan_addr : qa_addr;

	assign scan_prev = cnt_q - CNT_W'(1);
	assign scan_done = (cnt_q == CNT_W'(NUM_ACTIONS));

	assign reward = $signed({2'b00, quot_q}) - $signed({2'b00, (low_q ? penalty_q : 7'd0)});
	assign gval   = neg_q ? -$signed({1'b0, prod_q[RECIP_SHIFT+8:RECIP_SHIFT]})
		: $signed({1'b0, prod_q[RECIP_SHIFT+8:RECIP_SHIFT]});
	assign td     = (11'(reward) <<< 1) + 11'(gval) - 11'(q_q);
	assign td_abs = td[10] ? 11'(-td) : 11'(td);

	assign delta = neg_q ? -$signed({2'b00, prod_q[RECIP_SHIFT+9:RECIP_SHIFT]})
		: $signed({2'b00, prod_q[RECIP_SHIFT+9:RECIP_SHIFT]});
	assign q_new = 12'(q_q) + delta;

	always_comb begin
		priority if (q_new > VAL_MAX) begin
			q_sat = 8'(VAL_MAX);
		end else if (q_new < VAL_MIN) begin
			q_sat = 8'(VAL_MIN);
		end else begin
			q_sat = q_new[7:0];
		end
	end

	assign tbl_wr.en   = (state_q == ST_WR);
	assign tbl_wr.addr = qa_addr;
	assign tbl_wr.data = q_sat;

	qltu_value_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (tbl_wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign fin_load = (state_q == ST_FIN) && (!m_tvalid_q || m_axis_tready);

	always_comb begin
		priority if (pick_q == ACT_W'(0)) begin
			nudge = NUDGE_DOWN;
		end else if (pick_q == ACT_W'(2)) begin
			nudge = NUDGE_UP;
		end else begin
			nudge = NUDGE_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q   <= ALPHA_RST;
			gamma_q   <= GAMMA_RST;
			low_bat_q <= LOW_BAT_RST;
			penalty_q <= PENALTY_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ALPHA:   alpha_q   <= cfg_data;
				REG_GAMMA:   gamma_q   <= cfg_data;
				REG_LOW_BAT: low_bat_q <= cfg_data;
				REG_PENALTY: penalty_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			prev_state_q  <= '0;
			prev_action_q <= ACT_W'(1);
			div_cnt_q     <= '0;
			cnt_q         <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (fin_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && in_tot != 16'd0) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					div_cnt_q <= '0;
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + DCNT_W'(1);
					if (div_cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_SCAN1;
					end
				end
				ST_SCAN1: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (scan_done) begin
						state_q <= ST_RDQ;
					end
				end
				ST_RDQ: state_q <= ST_M1;
				ST_M1:  state_q <= ST_M2;
				ST_M2:  state_q <= ST_TD;
				ST_TD:  state_q <= ST_M3;
				ST_M3:  state_q <= ST_M4;
				ST_M4:  state_q <= ST_WR;
				ST_WR: begin
					cnt_q   <= '0;
					state_q <= ST_SCAN2;
				end
				ST_SCAN2: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (scan_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_load) begin
						prev_state_q  <= s2_q;
						prev_action_q <= pick_q;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ok_q  <= (in_ok > in_tot) ? in_tot : in_ok;
			tot_q <= in_tot;
			low_q <= (in_batt < low_bat_q);
			s2_q  <= in_bin;
		end
		if (state_q == ST_LOAD) begin
			rem_q  <= mul_p[22:0];
			dsr_q  <= {1'b0, tot_q, 6'b000000};
			quot_q <= '0;
		end
		if (state_q == ST_DIV) begin
			if (rem_q >= dsr_q) begin
				rem_q  <= rem_q - dsr_q;
				quot_q <= {quot_q[5:0], 1'b1};
			end else begin
				quot_q <= {quot_q[5:0], 1'b0};
			end
			dsr_q <= dsr_q >> 1;
		end
		if ((state_q == ST_SCAN1 || state_q == ST_SCAN2) && cnt_q != '0) begin
			if (cnt_q == CNT_W'(1) || rd_data > best_q) begin
				best_q <= rd_data;
				pick_q <= scan_prev[ACT_W-1:0];
			end
		end
		if (state_q == ST_M1) begin
			q_q    <= rd_data;
			neg_q  <= best_q[7];
		end
		if (state_q == ST_M1 || state_q == ST_M2 || state_q == ST_M3 || state_q == ST_M4) begin
			prod_q <= mul_p;
		end
		if (state_q == ST_TD) begin
			tdabs_q <= td_abs[9:0];
			neg_q   <= td[10];
		end
		if (state_q == ST_WR) begin
			upd_q <= q_sat;
		end
		if (fin_load) begin
			m_data_q <= {upd_q, s2_q, nudge, 2'(pick_q)};
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

[src/qltu_checker.sv]
module qltu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [39:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        cfg_ready
);
	import qltu_pkg::*;

	// A stalled output word keeps its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed while stalled");

	// A word with work to do makes the block busy at once, and it is still busy late in the update.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tdata[31:16] != 16'd0
		|=> !s_axis_tready)
		else $error("input taken again right after an update started");

	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tdata[31:16] != 16'd0
		|=> ##22 !s_axis_tready)
		else $error("update finished too early");

	// The nudge always matches the chosen action.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
		(m_axis_tdata[1:0] == 2'd0 && $signed(m_axis_tdata[5:2]) == NUDGE_DOWN) ||
		(m_axis_tdata[1:0] == 2'd2 && $signed(m_axis_tdata[5:2]) == NUDGE_UP) ||
		(m_axis_tdata[1:0] == 2'd1 && $signed(m_axis_tdata[5:2]) == NUDGE_NONE))
		else $error("nudge does not match chosen action");

	assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration channel not ready");

endmodule

bind qlearning_table_update_top qltu_checker u_qltu_checker (.*);
